@@ rtl/rvic_pkg.sv @@
package rvic_pkg;

  typedef logic [6:0] cls_t;

  typedef enum logic [2:0] {
    FMT_NONE,
    FMT_I,
    FMT_S,
    FMT_B,
    FMT_U,
    FMT_J
  } fmt_t;

  typedef struct packed {
    cls_t cls;
    fmt_t fmt;
  } dec_t;

  localparam logic [6:0] OP_REG    = 7'b0110011;
  localparam logic [6:0] OP_IMM    = 7'b0010011;
  localparam logic [6:0] OP_LOAD   = 7'b0000011;
  localparam logic [6:0] OP_STORE  = 7'b0100011;
  localparam logic [6:0] OP_BRANCH = 7'b1100011;
  localparam logic [6:0] OP_JAL    = 7'b1101111;
  localparam logic [6:0] OP_JALR   = 7'b1100111;
  localparam logic [6:0] OP_LUI    = 7'b0110111;
  localparam logic [6:0] OP_AUIPC  = 7'b0010111;
  localparam logic [6:0] OP_SYSTEM = 7'b1110011;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_W = 2'd3;

  localparam cls_t CLS_INVALID    = 7'd0;
  localparam cls_t CLS_ADD        = 7'd1;
  localparam cls_t CLS_SUB        = 7'd2;
  localparam cls_t CLS_XOR        = 7'd3;
  localparam cls_t CLS_OR         = 7'd4;
  localparam cls_t CLS_AND        = 7'd5;
  localparam cls_t CLS_SLL        = 7'd6;
  localparam cls_t CLS_SRL        = 7'd7;
  localparam cls_t CLS_SRA        = 7'd8;
  localparam cls_t CLS_SLT        = 7'd9;
  localparam cls_t CLS_SLTU       = 7'd10;
  localparam cls_t CLS_ADDI       = 7'd11;
  localparam cls_t CLS_XORI       = 7'd12;
  localparam cls_t CLS_ORI        = 7'd13;
  localparam cls_t CLS_ANDI       = 7'd14;
  localparam cls_t CLS_SLLI       = 7'd15;
  localparam cls_t CLS_SRLI       = 7'd16;
  localparam cls_t CLS_SRAI       = 7'd17;
  localparam cls_t CLS_SLTI       = 7'd18;
  localparam cls_t CLS_SLTIU      = 7'd19;
  localparam cls_t CLS_LB         = 7'd20;
  localparam cls_t CLS_LH         = 7'd21;
  localparam cls_t CLS_LW         = 7'd22;
  localparam cls_t CLS_LBU        = 7'd23;
  localparam cls_t CLS_LHU        = 7'd24;
  localparam cls_t CLS_SB         = 7'd25;
  localparam cls_t CLS_SH         = 7'd26;
  localparam cls_t CLS_SW         = 7'd27;
  localparam cls_t CLS_BEQ        = 7'd28;
  localparam cls_t CLS_BNE        = 7'd29;
  localparam cls_t CLS_BLT        = 7'd30;
  localparam cls_t CLS_BGE        = 7'd31;
  localparam cls_t CLS_BLTU       = 7'd32;
  localparam cls_t CLS_BGEU       = 7'd33;
  localparam cls_t CLS_JAL        = 7'd34;
  localparam cls_t CLS_JALR       = 7'd35;
  localparam cls_t CLS_LUI        = 7'd36;
  localparam cls_t CLS_AUIPC      = 7'd37;
  localparam cls_t CLS_ECALL      = 7'd38;
  localparam cls_t CLS_EBREAK     = 7'd39;
  localparam cls_t CLS_C_LW       = 7'd40;
  localparam cls_t CLS_C_SW       = 7'd41;
  localparam cls_t CLS_C_ADDI4SPN = 7'd42;
  localparam cls_t CLS_C_J        = 7'd43;
  localparam cls_t CLS_C_JAL      = 7'd44;
  localparam cls_t CLS_C_BEQZ     = 7'd45;
  localparam cls_t CLS_C_BNEZ     = 7'd46;
  localparam cls_t CLS_C_LI       = 7'd47;
  localparam cls_t CLS_C_ADDI16SP = 7'd48;
  localparam cls_t CLS_C_LUI      = 7'd49;
  localparam cls_t CLS_C_NOP      = 7'd50;
  localparam cls_t CLS_C_ADDI     = 7'd51;
  localparam cls_t CLS_C_SRLI     = 7'd52;
  localparam cls_t CLS_C_SRAI     = 7'd53;
  localparam cls_t CLS_C_ANDI     = 7'd54;
  localparam cls_t CLS_C_SUB      = 7'd55;
  localparam cls_t CLS_C_XOR      = 7'd56;
  localparam cls_t CLS_C_OR       = 7'd57;
  localparam cls_t CLS_C_AND      = 7'd58;
  localparam cls_t CLS_C_LWSP     = 7'd59;
  localparam cls_t CLS_C_SWSP     = 7'd60;
  localparam cls_t CLS_C_JR       = 7'd61;
  localparam cls_t CLS_C_MV       = 7'd62;
  localparam cls_t CLS_C_EBREAK   = 7'd63;
  localparam cls_t CLS_C_JALR     = 7'd64;
  localparam cls_t CLS_C_ADD      = 7'd65;
  localparam cls_t CLS_C_SLLI     = 7'd66;

  localparam logic [4:0] REG_SP = 5'd2;

endpackage

@@ rtl/rvic_classify.sv @@
module rvic_classify
  import rvic_pkg::*;
(
  input  logic [31:0] word,
  output dec_t        dec
);

  logic [2:0] f3;
  logic [6:0] f7;
  logic [4:0] crd;
  logic [4:0] crs2;
  cls_t       c_cls;
  cls_t       w_cls;
  fmt_t       w_fmt;

  assign f3   = word[14:12];
  assign f7   = word[31:25];
  assign crd  = word[11:7];
  assign crs2 = word[6:2];

  // Compressed forms use bits 15:13 as their function code.
  always_comb begin
    c_cls = CLS_INVALID;
    unique case (word[1:0])
      QUAD_0: begin
        unique case (word[15:13])
          3'd0:    c_cls = CLS_C_ADDI4SPN;
          3'd2:    c_cls = CLS_C_LW;
          3'd6:    c_cls = CLS_C_SW;
          default: c_cls = CLS_INVALID;
        endcase
      end
      QUAD_1: begin
        unique case (word[15:13])
          3'd0:    c_cls = (word[12:2] == 11'd0) ? CLS_C_NOP : CLS_C_ADDI;
          3'd1:    c_cls = CLS_C_JAL;
          3'd2:    c_cls = CLS_C_LI;
          3'd3:    c_cls = (crd == REG_SP) ? CLS_C_ADDI16SP : CLS_C_LUI;
          3'd5:    c_cls = CLS_C_J;
          3'd6:    c_cls = CLS_C_BEQZ;
          3'd7:    c_cls = CLS_C_BNEZ;
          default: begin
            unique case (word[11:10])
              2'd0:    c_cls = CLS_C_SRLI;
              2'd1:    c_cls = CLS_C_SRAI;
              2'd2:    c_cls = CLS_C_ANDI;
              default: begin
                unique case (word[6:5])
                  2'd0:    c_cls = CLS_C_SUB;
                  2'd1:    c_cls = CLS_C_XOR;
                  2'd2:    c_cls = CLS_C_OR;
                  default: c_cls = CLS_C_AND;
                endcase
              end
            endcase
          end
        endcase
      end
      QUAD_2: begin
        unique case (word[15:13])
          3'd0:    c_cls = CLS_C_SLLI;
          3'd2:    c_cls = CLS_C_LWSP;
          3'd6:    c_cls = CLS_C_SWSP;
          3'd4: begin
            priority if (!word[12]) begin
              c_cls = (crs2 == 5'd0) ? CLS_C_JR : CLS_C_MV;
            end else if (word[11:2] == 10'd0) begin
              c_cls = CLS_C_EBREAK;
            end else begin
              c_cls = (crs2 == 5'd0) ? CLS_C_JALR : CLS_C_ADD;
            end
          end
          default: c_cls = CLS_INVALID;
        endcase
      end
      default: c_cls = CLS_INVALID;
    endcase
  end

  always_comb begin
    w_cls = CLS_INVALID;
    w_fmt = FMT_NONE;
    unique case (word[6:0])
      OP_REG: begin
        if (f7 == F7_BASE) begin
          unique case (f3)
            3'd0:    w_cls = CLS_ADD;
            3'd1:    w_cls = CLS_SLL;
            3'd2:    w_cls = CLS_SLT;
            3'd3:    w_cls = CLS_SLTU;
            3'd4:    w_cls = CLS_XOR;
            3'd5:    w_cls = CLS_SRL;
            3'd6:    w_cls = CLS_OR;
            default: w_cls = CLS_AND;
          endcase
        end else if (f7 == F7_ALT) begin
          unique case (f3)
            3'd0:    w_cls = CLS_SUB;
            3'd5:    w_cls = CLS_SRA;
            default: w_cls = CLS_INVALID;
          endcase
        end
      end
      OP_IMM: begin
        w_fmt = FMT_I;
        unique case (f3)
          3'd0:    w_cls = CLS_ADDI;
          3'd1:    w_cls = CLS_SLLI;
          3'd2:    w_cls = CLS_SLTI;
          3'd3:    w_cls = CLS_SLTIU;
          3'd4:    w_cls = CLS_XORI;
          3'd5:    w_cls = word[30] ? CLS_SRAI : CLS_SRLI;
          3'd6:    w_cls = CLS_ORI;
          default: w_cls = CLS_ANDI;
        endcase
      end
      OP_LOAD: begin
        w_fmt = FMT_I;
        unique case (f3)
          3'd0:    w_cls = CLS_LB;
          3'd1:    w_cls = CLS_LH;
          3'd2:    w_cls = CLS_LW;
          3'd4:    w_cls = CLS_LBU;
          3'd5:    w_cls = CLS_LHU;
          default: w_cls = CLS_INVALID;
        endcase
      end
      OP_STORE: begin
        w_fmt = FMT_S;
        unique case (f3)
          3'd0:    w_cls = CLS_SB;
          3'd1:    w_cls = CLS_SH;
          3'd2:    w_cls = CLS_SW;
          default: w_cls = CLS_INVALID;
        endcase
      end
      OP_BRANCH: begin
        w_fmt = FMT_B;
        unique case (f3)
          3'd0:    w_cls = CLS_BEQ;
          3'd1:    w_cls = CLS_BNE;
          3'd4:    w_cls = CLS_BLT;
          3'd5:    w_cls = CLS_BGE;
          3'd6:    w_cls = CLS_BLTU;
          3'd7:    w_cls = CLS_BGEU;
          default: w_cls = CLS_INVALID;
        endcase
      end
      OP_JAL: begin
        w_fmt = FMT_J;
        w_cls = CLS_JAL;
      end
      OP_JALR: begin
        w_fmt = FMT_I;
        w_cls = CLS_JALR;
      end
      OP_LUI: begin
        w_fmt = FMT_U;
        w_cls = CLS_LUI;
      end
      OP_AUIPC: begin
        w_fmt = FMT_U;
        w_cls = CLS_AUIPC;
      end
      OP_SYSTEM: begin
        w_fmt = FMT_I;
        if (word[31:20] == 12'd0) begin
          w_cls = CLS_ECALL;
        end else if (word[31:20] == 12'd1) begin
          w_cls = CLS_EBREAK;
        end
      end
      default: begin
        w_cls = CLS_INVALID;
        w_fmt = FMT_NONE;
      end
    endcase
  end

  always_comb begin
    if (word[1:0] == QUAD_W) begin
      dec.cls = w_cls;
      dec.fmt = w_fmt;
    end else begin
      dec.cls = c_cls;
      dec.fmt = FMT_NONE;
    end
  end

endmodule

@@ rtl/rv32ic_instruction_classifier.sv @@
// Channel  | Handshake                  | Payload
// -------- | -------------------------- | ---------------------------------------------
// input    | in_valid / in_stall        | instruction_word
// output   | out_valid / out_stall      | instr_class, is_compressed, dest_reg,
//          |                            | src_reg_a, src_reg_b, immediate
//
// One beat is taken every cycle while the input is not stalled; a beat passes all register stages before it leaves.
// The three register stages are capture, class decode and field/immediate assembly.
// Reset empties all stages; payload registers are not reset.
// A stall holds each full stage; a bubble in the pipe still lets earlier stages move.
module rv32ic_instruction_classifier
  import rvic_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [31:0]        instruction_word,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [6:0]         instr_class,
  output logic               is_compressed,
  output logic [4:0]         dest_reg,
  output logic [4:0]         src_reg_a,
  output logic [4:0]         src_reg_b,
  output logic signed [31:0] immediate
);

  logic        v1;
  logic        v2;
  logic        v3;
  logic        en1;
  logic        en2;
  logic        en3;
  logic [31:0] w1;
  logic [31:0] w2;
  dec_t        dec1;
  dec_t        dec2;
  logic [31:0] imm_next;
  logic        zero_next;

  assign en3      = !v3 || !out_stall;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_stall = !en1;
  assign out_valid = v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= in_valid;
      end
      if (en2) begin
        v2 <= v1;
      end
      if (en3) begin
        v3 <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      w1 <= instruction_word;
    end
  end

  rvic_classify u_classify (
    .word (w1),
    .dec  (dec1)
  );

  always_ff @(posedge clk) begin
    if (en2) begin
      w2   <= w1;
      dec2 <= dec1;
    end
  end

  always_comb begin
    unique case (dec2.fmt)
      FMT_I:   imm_next = {{20{w2[31]}}, w2[31:20]};
      FMT_S:   imm_next = {{20{w2[31]}}, w2[31:25], w2[11:7]};
      FMT_B:   imm_next = {{20{w2[31]}}, w2[7], w2[30:25], w2[11:8], 1'b0};
      FMT_U:   imm_next = {w2[31:12], 12'd0};
      FMT_J:   imm_next = {{12{w2[31]}}, w2[19:12], w2[20], w2[30:21], 1'b0};
      default: imm_next = 32'd0;
    endcase
  end

  assign zero_next = (w2[1:0] != QUAD_W) || (dec2.cls == CLS_INVALID);

  always_ff @(posedge clk) begin
    if (en3) begin
      instr_class   <= dec2.cls;
      is_compressed <= (w2[1:0] != QUAD_W);
      dest_reg      <= zero_next ? 5'd0 : w2[11:7];
      src_reg_a     <= zero_next ? 5'd0 : w2[19:15];
      src_reg_b     <= zero_next ? 5'd0 : w2[24:20];
      immediate     <= zero_next ? 32'sd0 : $signed(imm_next);
    end
  end

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (v1 && v2 && v3 && out_stall))
    else $error("input stalled while the pipeline has room");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (is_compressed || instr_class == CLS_INVALID)) |->
      (dest_reg == 5'd0 && src_reg_a == 5'd0 && src_reg_b == 5'd0 && immediate == 32'sd0))
    else $error("register or immediate fields set for a compressed or invalid beat");

  a_class_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && instr_class != CLS_INVALID) |->
      (is_compressed ? (instr_class >= CLS_C_LW && instr_class <= CLS_C_SLLI)
                     : (instr_class <= CLS_EBREAK)))
    else $error("class code does not match the compressed flag");

  a_bubble_fill: assert property (@(posedge clk) disable iff (rst)
    (!v3 && v2) |=> v3)
    else $error("empty output stage did not take the decoded beat");

endmodule

@@ dv/rvic_decode_monitor.sv @@
module rvic_decode_monitor
  import rvic_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [31:0] instruction_word,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [6:0]  instr_class,
  input  logic        is_compressed,
  input  logic [4:0]  dest_reg,
  input  logic [4:0]  src_reg_a,
  input  logic [4:0]  src_reg_b,
  input  logic [31:0] immediate,
  output int          mismatches,
  output int          outstanding
);

  typedef struct packed {
    cls_t        cls;
    logic        comp;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [31:0] imm;
  } decode_t;

  decode_t pending_decodes[$];
  decode_t want;

  function automatic decode_t decode_instruction(logic [31:0] w);
    decode_t d;
    logic [2:0] f3;
    logic [31:0] imm_i;
    d = '0;
    f3 = w[14:12];
    imm_i = {{20{w[31]}}, w[31:20]};
    d.comp = (w[1:0] != QUAD_W);
    if (d.comp) begin
      case (w[1:0])
        QUAD_0: begin
          case (w[15:13])
            3'd2: d.cls = CLS_C_LW;
            3'd6: d.cls = CLS_C_SW;
            3'd0: d.cls = CLS_C_ADDI4SPN;
            default: d.cls = CLS_INVALID;
          endcase
        end
        QUAD_1: begin
          case (w[15:13])
            3'd5: d.cls = CLS_C_J;
            3'd1: d.cls = CLS_C_JAL;
            3'd6: d.cls = CLS_C_BEQZ;
            3'd7: d.cls = CLS_C_BNEZ;
            3'd2: d.cls = CLS_C_LI;
            3'd3: d.cls = (w[11:7] == REG_SP) ? CLS_C_ADDI16SP : CLS_C_LUI;
            3'd0: d.cls = (w[12:2] == '0) ? CLS_C_NOP : CLS_C_ADDI;
            default: begin
              case (w[11:10])
                2'd0: d.cls = CLS_C_SRLI;
                2'd1: d.cls = CLS_C_SRAI;
                2'd2: d.cls = CLS_C_ANDI;
                default: d.cls = CLS_C_SUB + cls_t'(w[6:5]);
              endcase
            end
          endcase
        end
        default: begin
          case (w[15:13])
            3'd2: d.cls = CLS_C_LWSP;
            3'd6: d.cls = CLS_C_SWSP;
            3'd0: d.cls = CLS_C_SLLI;
            3'd4: begin
              if (!w[12]) begin
                d.cls = (w[6:2] == '0) ? CLS_C_JR : CLS_C_MV;
              end else if (w[11:2] == '0) begin
                d.cls = CLS_C_EBREAK;
              end else begin
                d.cls = (w[6:2] == '0) ? CLS_C_JALR : CLS_C_ADD;
              end
            end
            default: d.cls = CLS_INVALID;
          endcase
        end
      endcase
    end else begin
      case (w[6:0])
        OP_REG: begin
          if (w[31:25] == F7_BASE) begin
            case (f3)
              3'd0: d.cls = CLS_ADD;
              3'd1: d.cls = CLS_SLL;
              3'd2: d.cls = CLS_SLT;
              3'd3: d.cls = CLS_SLTU;
              3'd4: d.cls = CLS_XOR;
              3'd5: d.cls = CLS_SRL;
              3'd6: d.cls = CLS_OR;
              default: d.cls = CLS_AND;
            endcase
          end else if (w[31:25] == F7_ALT) begin
            case (f3)
              3'd0: d.cls = CLS_SUB;
              3'd5: d.cls = CLS_SRA;
              default: d.cls = CLS_INVALID;
            endcase
          end
        end
        OP_IMM: begin
          case (f3)
            3'd0: d.cls = CLS_ADDI;
            3'd1: d.cls = CLS_SLLI;
            3'd2: d.cls = CLS_SLTI;
            3'd3: d.cls = CLS_SLTIU;
            3'd4: d.cls = CLS_XORI;
            3'd5: d.cls = w[30] ? CLS_SRAI : CLS_SRLI;
            3'd6: d.cls = CLS_ORI;
            default: d.cls = CLS_ANDI;
          endcase
          d.imm = imm_i;
        end
        OP_LOAD: begin
          case (f3)
            3'd0: d.cls = CLS_LB;
            3'd1: d.cls = CLS_LH;
            3'd2: d.cls = CLS_LW;
            3'd4: d.cls = CLS_LBU;
            3'd5: d.cls = CLS_LHU;
            default: d.cls = CLS_INVALID;
          endcase
          d.imm = imm_i;
        end
        OP_STORE: begin
          case (f3)
            3'd0: d.cls = CLS_SB;
            3'd1: d.cls = CLS_SH;
            3'd2: d.cls = CLS_SW;
            default: d.cls = CLS_INVALID;
          endcase
          d.imm = {{20{w[31]}}, w[31:25], w[11:7]};
        end
        OP_BRANCH: begin
          case (f3)
            3'd0: d.cls = CLS_BEQ;
            3'd1: d.cls = CLS_BNE;
            3'd4: d.cls = CLS_BLT;
            3'd5: d.cls = CLS_BGE;
            3'd6: d.cls = CLS_BLTU;
            3'd7: d.cls = CLS_BGEU;
            default: d.cls = CLS_INVALID;
          endcase
          d.imm = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
        end
        OP_JAL: begin
          d.cls = CLS_JAL;
          d.imm = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
        end
        OP_JALR: begin
          d.cls = CLS_JALR;
          d.imm = imm_i;
        end
        OP_LUI: begin
          d.cls = CLS_LUI;
          d.imm = {w[31:12], 12'd0};
        end
        OP_AUIPC: begin
          d.cls = CLS_AUIPC;
          d.imm = {w[31:12], 12'd0};
        end
        OP_SYSTEM: begin
          if (w[31:20] == 12'd0) begin
            d.cls = CLS_ECALL;
          end else if (w[31:20] == 12'd1) begin
            d.cls = CLS_EBREAK;
          end
          d.imm = imm_i;
        end
        default: d.cls = CLS_INVALID;
      endcase
    end
    if (d.comp || d.cls == CLS_INVALID) begin
      d.imm = '0;
    end else begin
      d.rd = w[11:7];
      d.rs1 = w[19:15];
      d.rs2 = w[24:20];
    end
    return d;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_val, act_val);
      mismatches++;
    end
  endtask

  initial begin
    mismatches = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      pending_decodes.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_decodes.size() == 0) begin
          $display("%0t: output beat with no instruction outstanding, class %0d",
                   $time, instr_class);
          mismatches++;
        end else begin
          want = pending_decodes.pop_front();
          check_field("instr_class", 32'(want.cls), 32'(instr_class));
          check_field("is_compressed", 32'(want.comp), 32'(is_compressed));
          check_field("dest_reg", 32'(want.rd), 32'(dest_reg));
          check_field("src_reg_a", 32'(want.rs1), 32'(src_reg_a));
          check_field("src_reg_b", 32'(want.rs2), 32'(src_reg_b));
          check_field("immediate", want.imm, immediate);
        end
      end
      if (in_valid && !in_stall) begin
        pending_decodes.push_back(decode_instruction(instruction_word));
      end
    end
    outstanding = pending_decodes.size();
  end

endmodule

@@ dv/testbench.sv @@
module testbench
  import rvic_pkg::*;
();

  localparam int CYCLE_LIMIT = 300000;
  localparam int RANDOM_BEATS = 700;
  localparam int FIRST_HOLD_AT = 200;
  localparam int LONG_HOLD = 400;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] instruction_word;
  logic        out_valid;
  logic        out_stall;
  logic [6:0]  instr_class;
  logic        is_compressed;
  logic [4:0]  dest_reg;
  logic [4:0]  src_reg_a;
  logic [4:0]  src_reg_b;
  logic signed [31:0] immediate;
  int          mismatches;
  int          outstanding;
  int          cycle_count = 0;

  logic [31:0] directed_words [23] = '{
    32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0033, 32'h41FF_8FB3, 32'hFE00_0033,
    32'h4000_5013, 32'hBFFF_D013, 32'hFE00_1013, 32'h0000_0073, 32'h0010_0073,
    32'h0020_0073, 32'h000F_FFF3, 32'hFFFF_F0B7, 32'h8000_0017, 32'hFFFF_F06F,
    32'h8000_0063, 32'hFFF0_2003, 32'h7E00_2FA3, 32'hFFFF_0001, 32'h0000_9002,
    32'h0000_6101, 32'h0000_2002, 32'h0000_2000
  };

  always #2 clk = ~clk;

  rv32ic_instruction_classifier dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .instruction_word (instruction_word),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .instr_class      (instr_class),
    .is_compressed    (is_compressed),
    .dest_reg         (dest_reg),
    .src_reg_a        (src_reg_a),
    .src_reg_b        (src_reg_b),
    .immediate        (immediate)
  );

  rvic_decode_monitor monitor (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .instruction_word (instruction_word),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .instr_class      (instr_class),
    .is_compressed    (is_compressed),
    .dest_reg         (dest_reg),
    .src_reg_a        (src_reg_a),
    .src_reg_b        (src_reg_b),
    .immediate        (immediate),
    .mismatches       (mismatches),
    .outstanding      (outstanding)
  );

  function automatic int idle_cycles(bit quiet);
    int r;
    r = $urandom_range(0, 9);
    if (quiet || r < 4) return 0;
    if (r < 8) return $urandom_range(1, 3);
    return $urandom_range(4, 16);
  endfunction

  function automatic logic [31:0] gen_word();
    logic [31:0] w;
    int pick;
    w = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      case ($urandom_range(0, 9))
        0: w[6:0] = OP_REG;
        1: w[6:0] = OP_IMM;
        2: w[6:0] = OP_LOAD;
        3: w[6:0] = OP_STORE;
        4: w[6:0] = OP_BRANCH;
        5: w[6:0] = OP_JAL;
        6: w[6:0] = OP_JALR;
        7: w[6:0] = OP_LUI;
        8: w[6:0] = OP_AUIPC;
        default: w[6:0] = OP_SYSTEM;
      endcase
      if (w[6:0] == OP_REG && $urandom_range(0, 3) != 0) begin
        w[31:25] = $urandom_range(0, 1) ? F7_ALT : F7_BASE;
      end
      if (w[6:0] == OP_SYSTEM && $urandom_range(0, 3) != 0) begin
        w[31:20] = 12'($urandom_range(0, 1));
      end
    end else if (pick < 80) begin
      w[1:0] = 2'($urandom_range(0, 2));
      case ($urandom_range(0, 9))
        0: w[12:2] = '0;
        1: begin
          w[15:12] = 4'b1001;
          w[11:2] = '0;
        end
        2: w[6:2] = '0;
        3: w[11:7] = REG_SP;
        default: ;
      endcase
    end
    return w;
  endfunction

  task automatic send_beat(input logic [31:0] word, input int gap);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    instruction_word = word;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int hold;
    int taken;
    bit quiet;
    taken = 0;
    quiet = 1'b0;
    out_stall = 1'b0;
    do @(negedge clk); while (rst);
    forever begin
      if (taken % 64 == 0) quiet = ($urandom_range(0, 3) == 0);
      hold = (taken == FIRST_HOLD_AT) ? LONG_HOLD : idle_cycles(quiet);
      if (hold > 0) begin
        out_stall = 1'b1;
        repeat (hold) @(negedge clk);
        out_stall = 1'b0;
      end
      do @(posedge clk); while (!out_valid);
      taken++;
      @(negedge clk);
    end
  end

  initial begin
    bit quiet;
    rst = 1'b1;
    in_valid = 1'b0;
    instruction_word = '0;
    quiet = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    foreach (directed_words[i]) begin
      send_beat(directed_words[i], idle_cycles(1'b0));
    end
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n % 50 == 0) quiet = ($urandom_range(0, 3) == 0);
      send_beat(gen_word(), idle_cycles(quiet));
    end
    in_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
